[sv/rcvtm_pkg.sv]
// Shared types, constants and register codes for the rail current/voltage trip monitor.
// Used by rcvtm_step and by the top level; depends on nothing else.
package rcvtm_pkg;

    // Field widths.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned EVVAL_W  = 15;
    localparam int unsigned WARM_W   = 4;
    localparam int unsigned IDX_W    = 2;

    // Filter and warmup constants.
    localparam int unsigned FILTER_SHIFT = 3;
    localparam logic [WARM_W-1:0] WARMUP_SAMPLES = WARM_W'(8);
    localparam int unsigned ACC_W = SAMPLE_W + FILTER_SHIFT + 1;

    // Packed stream widths.
    localparam int unsigned IN_DATA_W  = 2 * SAMPLE_W;
    localparam int unsigned OUT_BITS   = 2 * SAMPLE_W + 7 + 2 * EVVAL_W;
    localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Command codes carried in tuser.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_CURRENT_LIMIT = 2'd0;
    localparam logic [IDX_W-1:0] REG_UV_CRITICAL   = 2'd1;
    localparam logic [IDX_W-1:0] REG_UV_WARN       = 2'd2;

    // Configuration reset values.
    localparam logic [SAMPLE_W-1:0] CURRENT_LIMIT_RST = 16'd10000;
    localparam logic [SAMPLE_W-1:0] UV_CRITICAL_RST   = 16'd4500;
    localparam logic [SAMPLE_W-1:0] UV_WARN_RST       = 16'd4800;

    typedef struct packed {
        logic [SAMPLE_W-1:0] oc_threshold_ma;
        logic [SAMPLE_W-1:0] uv_critical_mv;
        logic [SAMPLE_W-1:0] uv_warn_mv;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] current_filter;
        logic                filter_seeded;
        logic [WARM_W-1:0]   warmup_count;
        logic [SAMPLE_W-1:0] voltage_held;
        logic                oc_trip_latch;
        logic                uv_trip_latch;
        logic                uv_warn_flag;
    } mon_state_t;

    typedef struct packed {
        logic                disable_all;
        logic [EVVAL_W-1:0]  event_voltage_value;
        logic [EVVAL_W-1:0]  event_current_value;
        logic                undervoltage_warn_event;
        logic                undervoltage_trip_event;
        logic                overcurrent_event;
        logic                uv_warning_active;
        logic                undervoltage_latched;
        logic                overcurrent_latched;
        logic [SAMPLE_W-1:0] held_voltage_mv;
        logic [SAMPLE_W-1:0] smoothed_current_ma;
    } result_t;

endpackage

[sv/rcvtm_step.sv]
// Per-item update of the monitor: filter, warmup counter, trip latches and warning.
// Purely combinational; uses rcvtm_pkg for the state, config and result structs.
module rcvtm_step
    import rcvtm_pkg::*;
(
    input  cfg_t                cfg,
    input  mon_state_t          state,
    input  logic                cmd,
    input  logic [SAMPLE_W-1:0] current_ma,
    input  logic [SAMPLE_W-1:0] voltage_mv,
    output mon_state_t          state_next,
    output result_t             result
);

    logic [ACC_W-1:0]    acc;
    logic [SAMPLE_W-1:0] filt_upd;
    logic                oc_ev;
    logic                uv_ev;
    logic                warn_ev;

    // Smoothing: ((2^shift - 1) * old + new) >> shift, with the multiply as shift minus old.
    always_comb
    begin
        acc = ({{1{1'b0}}, state.current_filter, {FILTER_SHIFT{1'b0}}})
              - ACC_W'(state.current_filter) + ACC_W'(current_ma);
        filt_upd = acc[FILTER_SHIFT +: SAMPLE_W];
    end

    // State update and trip decisions.
    always_comb
    begin
        state_next = state;
        oc_ev      = 1'b0;
        uv_ev      = 1'b0;
        warn_ev    = 1'b0;
        if (cmd == CMD_CLEAR)
        begin
            state_next.current_filter = '0;
            state_next.filter_seeded  = 1'b0;
            state_next.warmup_count   = '0;
            state_next.oc_trip_latch  = 1'b0;
            state_next.uv_trip_latch  = 1'b0;
        end
        else
        begin
            state_next.current_filter = state.filter_seeded ? filt_upd : current_ma;
            state_next.filter_seeded  = 1'b1;
            state_next.voltage_held   = voltage_mv;
            if (state.warmup_count < WARMUP_SAMPLES)
            begin
                state_next.warmup_count = state.warmup_count + WARM_W'(1);
            end
            else
            begin
                if (!state.oc_trip_latch
                    && (state_next.current_filter > cfg.oc_threshold_ma))
                begin
                    state_next.oc_trip_latch = 1'b1;
                    oc_ev = 1'b1;
                end
                // A voltage below critical with the latch already set falls to the warning test.
                if ((voltage_mv < cfg.uv_critical_mv) && !state.uv_trip_latch)
                begin
                    state_next.uv_trip_latch = 1'b1;
                    uv_ev = 1'b1;
                end
                else if (voltage_mv < cfg.uv_warn_mv)
                begin
                    if (!state.uv_warn_flag)
                    begin
                        state_next.uv_warn_flag = 1'b1;
                        warn_ev = 1'b1;
                    end
                end
                else
                begin
                    state_next.uv_warn_flag = 1'b0;
                end
            end
        end
    end

    // Result item built from the updated state.
    always_comb
    begin
        result.smoothed_current_ma     = state_next.current_filter;
        result.held_voltage_mv         = state_next.voltage_held;
        result.overcurrent_latched     = state_next.oc_trip_latch;
        result.undervoltage_latched    = state_next.uv_trip_latch;
        result.uv_warning_active       = state_next.uv_warn_flag;
        result.overcurrent_event       = oc_ev;
        result.undervoltage_trip_event = uv_ev;
        result.undervoltage_warn_event = warn_ev;
        result.event_current_value     = oc_ev ? state_next.current_filter[EVVAL_W-1:0] : '0;
        result.event_voltage_value     = (uv_ev || warn_ev)
                                         ? state_next.voltage_held[EVVAL_W-1:0] : '0;
        result.disable_all             = oc_ev || uv_ev;
    end

endmodule

[sv/rail_current_voltage_trip_monitor_top.sv]
// Top level of the rail current/voltage trip monitor: stream ports, config registers,
// input and result registers. Depends on rcvtm_pkg and rcvtm_step.
//
//   Channel   Signals                                   Direction  Moves
//   s_axis    tvalid tready tdata[31:0] tuser[0]        in         sample pair or clear item
//   m_axis    tvalid tready tdata[71:0]                 out        one result item per input
//   cfg       valid ready index[1:0] data[15:0]         in         register write, always ready
//
// An item passes through the input register and then the result register, and one item is
// taken every cycle while m_axis_tready stays high; the filter and latch update is
// combinational between the two registers.
// Reset clears the control state and loads the register defaults; no sweep is needed.
// A stalled result holds the result register, and the input register still takes one item.
module rail_current_voltage_trip_monitor_top
    import rcvtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // current_ma[15:0], voltage_mv[31:16]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // smoothed_current_ma[15:0], held_voltage_mv[31:16], overcurrent_latched[32],
    // undervoltage_latched[33], uv_warning_active[34], overcurrent_event[35],
    // undervoltage_trip_event[36], undervoltage_warn_event[37],
    // event_current_value[52:38], event_voltage_value[67:53], disable_all[68], zeros above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [SAMPLE_W-1:0]   cfg_data
);

    cfg_t                cfg_reg;
    mon_state_t          state_reg;
    mon_state_t          state_next;
    result_t             result_next;
    result_t             result_reg;
    logic                in_valid_reg;
    logic                in_cmd_reg;
    logic [SAMPLE_W-1:0] in_current_reg;
    logic [SAMPLE_W-1:0] in_voltage_reg;
    logic                out_valid_reg;
    logic                advance;

    assign cfg_ready = 1'b1;

    // Configuration registers; unlisted indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.oc_threshold_ma <= CURRENT_LIMIT_RST;
            cfg_reg.uv_critical_mv  <= UV_CRITICAL_RST;
            cfg_reg.uv_warn_mv      <= UV_WARN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CURRENT_LIMIT: cfg_reg.oc_threshold_ma <= cfg_data;
                REG_UV_CRITICAL:   cfg_reg.uv_critical_mv  <= cfg_data;
                REG_UV_WARN:       cfg_reg.uv_warn_mv      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // The held item moves on when the result register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg     <= s_axis_tuser;
            in_current_reg <= s_axis_tdata[SAMPLE_W-1:0];
            in_voltage_reg <= s_axis_tdata[IN_DATA_W-1:SAMPLE_W];
        end
    end

    rcvtm_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .cmd        (in_cmd_reg),
        .current_ma (in_current_reg),
        .voltage_mv (in_voltage_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Monitor state and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, result_reg};

endmodule

[tb/tb_rail_current_voltage_trip_monitor_top.sv]
`timescale 1ns / 100ps
// Testbench for rail_current_voltage_trip_monitor_top. A scoreboard class predicts the filter,
// trip latches, warning and events for every item and checks each result item field by field.
// Depends on rcvtm_pkg and the block's RTL; needs nothing else.

import rcvtm_pkg::*;

// Tracks the monitor's state and registers, and holds the results still owed by the block.
class trip_scoreboard_t;
    // Register copies.
    logic [SAMPLE_W-1:0] oc_thr_ma;
    logic [SAMPLE_W-1:0] crit_mv;
    logic [SAMPLE_W-1:0] warn_mv;
    // Monitor state.
    logic [SAMPLE_W-1:0] filt;
    logic                seeded;
    logic [WARM_W-1:0]   warm;
    logic [SAMPLE_W-1:0] volt;
    logic                oc_lat;
    logic                uv_lat;
    logic                warn_flag;
    result_t             pending_results[$];
    // Tallies.
    int                  errors;
    int                  n_items;
    int                  n_checked;
    int                  n_clears;
    int                  n_oc_trips;
    int                  n_uv_trips;
    int                  n_warnings;

    function new();
        oc_thr_ma  = CURRENT_LIMIT_RST;
        crit_mv    = UV_CRITICAL_RST;
        warn_mv    = UV_WARN_RST;
        filt       = '0;
        seeded     = 1'b0;
        warm       = '0;
        volt       = '0;
        oc_lat     = 1'b0;
        uv_lat     = 1'b0;
        warn_flag  = 1'b0;
        errors     = 0;
        n_items    = 0;
        n_checked  = 0;
        n_clears   = 0;
        n_oc_trips = 0;
        n_uv_trips = 0;
        n_warnings = 0;
    endfunction

    function void write_register(logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
        case (idx)
            REG_CURRENT_LIMIT: oc_thr_ma = val;
            REG_UV_CRITICAL:   crit_mv = val;
            REG_UV_WARN:       warn_mv = val;
            default:           ;
        endcase
    endfunction

    // Advance the monitor by one accepted item and queue the result it must produce.
    function void take_item(logic cmd, logic [SAMPLE_W-1:0] cur, logic [SAMPLE_W-1:0] vol);
        logic [ACC_W-1:0] acc;
        result_t          r;
        r = '0;
        n_items++;
        if (cmd == CMD_CLEAR) begin
            // Clear keeps the held voltage and the warning.
            filt   = '0;
            seeded = 1'b0;
            warm   = '0;
            oc_lat = 1'b0;
            uv_lat = 1'b0;
            n_clears++;
        end
        else begin
            if (!seeded) begin
                filt   = cur;
                seeded = 1'b1;
            end
            else begin
                acc  = ACC_W'(filt) * ACC_W'((1 << FILTER_SHIFT) - 1) + ACC_W'(cur);
                filt = SAMPLE_W'(acc >> FILTER_SHIFT);
            end
            volt = vol;
            if (warm < WARMUP_SAMPLES) begin
                warm = warm + 1'b1;
            end
            else begin
                if (!oc_lat && filt > oc_thr_ma) begin
                    oc_lat              = 1'b1;
                    r.overcurrent_event = 1'b1;
                end
                // With the trip already latched a low voltage drops to the warning test.
                if (volt < crit_mv && !uv_lat) begin
                    uv_lat                    = 1'b1;
                    r.undervoltage_trip_event = 1'b1;
                end
                else if (volt < warn_mv) begin
                    if (!warn_flag) begin
                        warn_flag                 = 1'b1;
                        r.undervoltage_warn_event = 1'b1;
                    end
                end
                else begin
                    warn_flag = 1'b0;
                end
            end
        end
        r.smoothed_current_ma  = filt;
        r.held_voltage_mv      = volt;
        r.overcurrent_latched  = oc_lat;
        r.undervoltage_latched = uv_lat;
        r.uv_warning_active    = warn_flag;
        if (r.overcurrent_event) begin
            r.event_current_value = filt[EVVAL_W-1:0];
            n_oc_trips++;
        end
        if (r.undervoltage_trip_event || r.undervoltage_warn_event) begin
            r.event_voltage_value = volt[EVVAL_W-1:0];
        end
        if (r.undervoltage_trip_event) n_uv_trips++;
        if (r.undervoltage_warn_event) n_warnings++;
        r.disable_all = r.overcurrent_event | r.undervoltage_trip_event;
        pending_results.push_back(r);
    endfunction

    task report(string msg);
        // Keep the log short when the block is badly broken.
        if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task compare(string field, logic [SAMPLE_W-1:0] got, logic [SAMPLE_W-1:0] want);
        if (got !== want) begin
            report($sformatf("result %0d field %s: got %0h, expected %0h",
                             n_checked, field, got, want));
        end
    endtask

    task check_result(logic [OUT_DATA_W-1:0] word);
        result_t got;
        result_t want;
        got = result_t'(word[OUT_BITS-1:0]);
        if (pending_results.size() == 0) begin
            report($sformatf("result item %0h arrived with nothing expected", word));
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        compare("smoothed_current_ma", got.smoothed_current_ma, want.smoothed_current_ma);
        compare("held_voltage_mv", got.held_voltage_mv, want.held_voltage_mv);
        compare("overcurrent_latched", got.overcurrent_latched, want.overcurrent_latched);
        compare("undervoltage_latched", got.undervoltage_latched, want.undervoltage_latched);
        compare("uv_warning_active", got.uv_warning_active, want.uv_warning_active);
        compare("overcurrent_event", got.overcurrent_event, want.overcurrent_event);
        compare("undervoltage_trip_event", got.undervoltage_trip_event,
                want.undervoltage_trip_event);
        compare("undervoltage_warn_event", got.undervoltage_warn_event,
                want.undervoltage_warn_event);
        compare("event_current_value", got.event_current_value, want.event_current_value);
        compare("event_voltage_value", got.event_voltage_value, want.event_voltage_value);
        compare("disable_all", got.disable_all, want.disable_all);
        compare("padding", word[OUT_DATA_W-1:OUT_BITS], '0);
    endtask
endclass

module tb_rail_current_voltage_trip_monitor_top;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned PHASE_ITEMS    = 90;
    localparam int          SAMPLE_MAX     = 2 ** SAMPLE_W - 1;
    localparam logic [IDX_W-1:0] REG_UNLISTED = 2'd3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_CHOKED
    } rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index;
    logic [SAMPLE_W-1:0]   cfg_data;

    trip_scoreboard_t sb;
    int               tx_burst_left;
    int               idle_cycles  = 0;
    rx_mode_t         rx_mode      = RX_OPEN;
    int               rx_mode_left = 0;
    int               rx_phase     = 0;

    rail_current_voltage_trip_monitor_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Result side: ready follows a randomly chosen mode: open, random, periodic or choked.
    always @(negedge clk)
    begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 80);
        end
        else begin
            rx_mode_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_axis_tready <= ((rx_phase % 5) >= 3);
            default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Handshake monitor: feeds the scoreboard and watches for a stuck block.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.take_item(s_axis_tuser, s_axis_tdata[SAMPLE_W-1:0],
                             s_axis_tdata[IN_DATA_W-1:SAMPLE_W]);
            end
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end
            else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                         idle_cycles, sb.pending_results.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Sender pacing: bursts of random length separated by short gaps.
    task automatic pace();
        int gap;
        if (tx_burst_left > 0) begin
            tx_burst_left--;
        end
        else begin
            tx_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Called at a falling edge; returns at a falling edge once the item is taken and any pacing gap has passed.
    task automatic send_item(logic cmd, logic [SAMPLE_W-1:0] cur, logic [SAMPLE_W-1:0] vol);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {vol, cur};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        pace();
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Hold off input until every owed result has come out, then let the pipe settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] near(logic [SAMPLE_W-1:0] thr, int span);
        int v;
        v = int'(thr) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    // Voltages cluster at both thresholds, with a healthy level now and then to clear warnings.
    function automatic logic [SAMPLE_W-1:0] pick_voltage();
        logic [SAMPLE_W-1:0] top;
        top = (sb.crit_mv > sb.warn_mv) ? sb.crit_mv : sb.warn_mv;
        case ($urandom_range(0, 9))
            0, 1:    return near(sb.crit_mv, 8);
            2, 3:    return near(sb.warn_mv, 8);
            4, 5:    return SAMPLE_W'($urandom);
            6:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return near(top, 2000) | ((top == '1) ? '1 : '0);
        endcase
    endfunction

    // Currents mostly hover at the limit so the filter drifts across it.
    function automatic logic [SAMPLE_W-1:0] pick_current();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return near(sb.oc_thr_ma, 16);
            4, 5:       return near(sb.oc_thr_ma, 1500);
            6, 7:       return SAMPLE_W'($urandom);
            default:    return ($urandom_range(0, 1) != 0) ? '1 : '0;
        endcase
    endfunction

    // Mostly sample runs long enough to pass warmup, with stray clears and raw noise.
    task automatic run_phase(int n_items);
        int k;
        send_item(CMD_CLEAR, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        for (k = 1; k < n_items; k++) begin
            case ($urandom_range(0, 39))
                0:       send_item(CMD_CLEAR, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                1, 2, 3: send_item(1'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                default: send_item(CMD_SAMPLE, pick_current(), pick_voltage());
            endcase
            if ($urandom_range(0, 59) == 0) drain();
        end
        drain();
    endtask

    initial
    begin
        int lo;
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_SAMPLE;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_CURRENT_LIMIT;
        cfg_data      = '0;
        tx_burst_left = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset registers. Seed at zero, then full-scale current through warmup at 0 V.
        send_item(CMD_SAMPLE, '0, '0);
        repeat (7) send_item(CMD_SAMPLE, '1, '0);
        // Both trips fire together; the current value needs masking to 15 bits.
        send_item(CMD_SAMPLE, '1, '0);
        // Undervoltage already latched, so the low voltage raises the warning instead.
        send_item(CMD_SAMPLE, '1, '0);
        send_item(CMD_SAMPLE, '0, 16'd4600);
        send_item(CMD_SAMPLE, '0, '1);
        send_item(CMD_SAMPLE, '0, 16'd4799);
        // Clears ignore their data and keep the warning; a second one changes nothing more.
        send_item(CMD_CLEAR, '1, '1);
        send_item(CMD_CLEAR, '0, '0);
        // Warmup hides values that would trip, then each threshold is met exactly.
        repeat (8) send_item(CMD_SAMPLE, 16'd10001, 16'd4499);
        send_item(CMD_SAMPLE, 16'd10001, 16'd4500);
        send_item(CMD_SAMPLE, 16'd10001, 16'd4499);
        drain();

        // All thresholds at zero: any nonzero current trips, no voltage does.
        write_reg(REG_CURRENT_LIMIT, '0);
        write_reg(REG_UV_CRITICAL, '0);
        write_reg(REG_UV_WARN, '0);
        run_phase(PHASE_ITEMS);

        // All thresholds at full scale: current never trips, nearly every voltage does.
        write_reg(REG_CURRENT_LIMIT, '1);
        write_reg(REG_UV_CRITICAL, '1);
        write_reg(REG_UV_WARN, '1);
        run_phase(PHASE_ITEMS);

        // Random ordered thresholds, plus a write to an index with no register behind it.
        lo = $urandom_range(0, 50000);
        write_reg(REG_CURRENT_LIMIT, SAMPLE_W'($urandom));
        write_reg(REG_UV_CRITICAL, SAMPLE_W'(lo));
        write_reg(REG_UV_WARN, SAMPLE_W'(lo + $urandom_range(1, 15000)));
        write_reg(REG_UNLISTED, SAMPLE_W'($urandom));
        run_phase(PHASE_ITEMS);

        // Warning level under the critical level, so the warning can only follow a trip.
        write_reg(REG_CURRENT_LIMIT, SAMPLE_W'($urandom_range(1, 40000)));
        write_reg(REG_UV_CRITICAL, SAMPLE_W'($urandom_range(30000, 40000)));
        write_reg(REG_UV_WARN, SAMPLE_W'($urandom_range(10000, 29999)));
        run_phase(PHASE_ITEMS);

        // Back to the reset values; the unlisted index must still do nothing.
        write_reg(REG_CURRENT_LIMIT, CURRENT_LIMIT_RST);
        write_reg(REG_UV_CRITICAL, UV_CRITICAL_RST);
        write_reg(REG_UV_WARN, UV_WARN_RST);
        write_reg(REG_UNLISTED, '1);
        run_phase(PHASE_ITEMS);

        drain();
        repeat (8) @(negedge clk);
        if (sb.pending_results.size() != 0) begin
            sb.report($sformatf("%0d expected results never arrived",
                                sb.pending_results.size()));
        end
        $display("%0d input items (%0d clears) over six register settings, %0d results checked",
                 sb.n_items, sb.n_clears, sb.n_checked);
        $display("events: %0d overcurrent trips, %0d undervoltage trips, %0d warnings",
                 sb.n_oc_trips, sb.n_uv_trips, sb.n_warnings);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end
        else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
